// File: rtl/cfna_pkg.sv
// Package: shared widths, job record, state types and helper of the node allocator.
`default_nettype none
package cfna_pkg;

  localparam int unsigned NODES_DEF   = 64;
  localparam int unsigned MASK_W      = 64;
  localparam int unsigned REQ_W       = 7;
  localparam int unsigned QDEPTH_DEF  = 2;
  localparam int unsigned CHUNK_W     = 8;

  localparam logic STATUS_GRANTED = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [REQ_W-1:0]  count;
    logic              refuse;
  } job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_COUNT,
    FR_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_PICK,
    BK_CLAIM,
    BK_DONE
  } back_state_e;

  function automatic logic [3:0] popcount8(input logic [CHUNK_W-1:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      c = c + {3'b000, v[i]};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cfna_if.sv
// Interfaces: request and response channels of the node allocator.
`default_nettype none
interface cfna_req_if;
  import cfna_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] avail_mask;
  logic [REQ_W-1:0]  request_count;

  modport source (output valid, output avail_mask, output request_count, input ready);
  modport sink   (input valid, input avail_mask, input request_count, output ready);
endinterface

interface cfna_rsp_if;
  import cfna_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] granted_mask;
  logic [REQ_W-1:0]  granted_count;
  logic              status;

  modport source (output valid, output granted_mask, output granted_count, output status,
                  input ready);
  modport sink   (input valid, input granted_mask, input granted_count, input status,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/cfna_front.sv
// Front end: accepts a request, counts free nodes a byte per cycle, classifies it.
`default_nettype none
module cfna_front #(
  parameter int unsigned NODES = cfna_pkg::NODES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  cfna_req_if.sink            req_i,
  output cfna_pkg::job_t      job_o,
  output logic                job_valid_o,
  input  wire logic           job_ready_i
);
  import cfna_pkg::*;

  localparam int unsigned NumChunks = (NODES + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned PadW      = NumChunks * CHUNK_W;
  localparam int unsigned CntW      = (NumChunks > 1) ? $clog2(NumChunks) : 1;
  localparam int unsigned OnesW     = $clog2(NODES + 1);

  front_state_e        state_q, state_d;
  logic [PadW-1:0]     shift_q, shift_d;
  logic [NODES-1:0]    mask_q, mask_d;
  logic [REQ_W-1:0]    count_q, count_d;
  logic [OnesW-1:0]    ones_q, ones_d;
  logic [CntW-1:0]     chunk_q, chunk_d;
  logic                last_chunk;
  logic                accept;

  assign accept     = req_i.valid && req_i.ready;
  assign last_chunk = (chunk_q == CntW'(NumChunks - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE:  if (req_i.valid) state_d = FR_COUNT;
      FR_COUNT: if (last_chunk) state_d = FR_PUSH;
      FR_PUSH:  if (job_ready_i) state_d = FR_IDLE;
      default:  state_d = FR_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    shift_d     = shift_q;
    mask_d      = mask_q;
    count_d     = count_q;
    ones_d      = ones_q;
    chunk_d     = chunk_q;
    req_i.ready = (state_q == FR_IDLE);
    job_valid_o = (state_q == FR_PUSH);
    job_o.mask   = MASK_W'(mask_q);
    job_o.count  = count_q;
    job_o.refuse = (count_q == '0) || (count_q > REQ_W'(ones_q));
    if (accept) begin
      // Nodes above the configured count are never free.
      mask_d  = req_i.avail_mask[NODES-1:0];
      shift_d = PadW'(req_i.avail_mask[NODES-1:0]);
      count_d = req_i.request_count;
      ones_d  = '0;
      chunk_d = '0;
    end else if (state_q == FR_COUNT) begin
      ones_d  = ones_q + OnesW'(popcount8(shift_q[CHUNK_W-1:0]));
      shift_d = shift_q >> CHUNK_W;
      chunk_d = chunk_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    mask_q  <= mask_d;
    count_q <= count_d;
    ones_q  <= ones_d;
    chunk_q <= chunk_d;
  end

endmodule
`default_nettype wire

// File: rtl/cfna_fifo.sv
// Short job queue between the front and the back end.
`default_nettype none
module cfna_fifo #(
  parameter int unsigned DEPTH = cfna_pkg::QDEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cfna_pkg::job_t push_data_i,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  output cfna_pkg::job_t      pop_data_o,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i
);
  import cfna_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FillW = $clog2(DEPTH + 1);

  job_t             slot_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = (fill_q != FillW'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push) wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (push && !pop)      fill_d = fill_q + 1'b1;
    else if (pop && !push) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// File: rtl/cfna_back.sv
// Back end: claims windows of free nodes round by round and registers the result.
`default_nettype none
module cfna_back #(
  parameter int unsigned NODES = cfna_pkg::NODES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cfna_pkg::job_t job_i,
  input  wire logic           job_valid_i,
  output logic                job_ready_o,
  cfna_rsp_if.source          rsp_o
);
  import cfna_pkg::*;

  localparam int unsigned LenW = $clog2(NODES + 1);

  back_state_e       state_q, state_d;
  logic [NODES-1:0]  work_q, work_d;
  logic [NODES-1:0]  run_q, run_d;
  logic [NODES-1:0]  grant_q, grant_d;
  logic [NODES-1:0]  top_q, top_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   remain_q, remain_d;
  logic [REQ_W-1:0]  want_q, want_d;
  logic              refuse_q, refuse_d;
  logic              out_valid_q, out_valid_d;
  logic [MASK_W-1:0] out_mask_q, out_mask_d;
  logic [REQ_W-1:0]  out_count_q, out_count_d;
  logic              out_status_q, out_status_d;

  logic [NODES-1:0]  run_next;
  logic              scan_stop;
  logic [NODES-1:0]  smear;
  logic [NODES:0]    window_ext;
  logic [NODES-1:0]  window;
  logic [LenW-1:0]   remain_left;
  logic              out_free;

  // Starts of runs one longer than the current length.
  assign run_next  = run_q & (work_q >> len_q);
  assign scan_stop = (len_q == remain_q) || (run_next == '0);

  // Isolate the highest run start.
  always_comb begin
    smear = run_q;
    for (int s = 1; s < NODES; s = s * 2) begin
      smear = smear | (smear >> s);
    end
  end

  assign window_ext  = ({1'b0, top_q} << len_q) - {1'b0, top_q};
  assign window      = window_ext[NODES-1:0];
  assign remain_left = remain_q - len_q;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) state_d = job_i.refuse ? BK_DONE : BK_SCAN;
      end
      BK_SCAN: begin
        if (run_q == '0)    state_d = BK_DONE;
        else if (scan_stop) state_d = BK_PICK;
      end
      BK_PICK:  state_d = BK_CLAIM;
      BK_CLAIM: state_d = (remain_left == '0) ? BK_DONE : BK_SCAN;
      BK_DONE:  if (out_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    work_d       = work_q;
    run_d        = run_q;
    grant_d      = grant_q;
    top_d        = top_q;
    len_d        = len_q;
    remain_d     = remain_q;
    want_d       = want_q;
    refuse_d     = refuse_q;
    out_mask_d   = out_mask_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    job_ready_o  = (state_q == BK_IDLE);

    unique case (state_q)
      BK_IDLE: begin
        work_d   = job_i.mask[NODES-1:0];
        run_d    = job_i.mask[NODES-1:0];
        grant_d  = '0;
        len_d    = LenW'(1);
        remain_d = job_i.count[LenW-1:0];
        want_d   = job_i.count;
        refuse_d = job_i.refuse;
      end
      BK_SCAN: begin
        if (run_q == '0) begin
          refuse_d = 1'b1;
        end else if (!scan_stop) begin
          run_d = run_next;
          len_d = len_q + 1'b1;
        end
      end
      BK_PICK: begin
        top_d = run_q & ~(smear >> 1);
      end
      BK_CLAIM: begin
        work_d   = work_q & ~window;
        grant_d  = grant_q | window;
        remain_d = remain_left;
        run_d    = work_q & ~window;
        len_d    = LenW'(1);
      end
      BK_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_mask_d   = refuse_q ? '0 : MASK_W'(grant_q);
          out_count_d  = refuse_q ? '0 : want_q;
          out_status_d = refuse_q ? STATUS_REFUSED : STATUS_GRANTED;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.granted_mask  = out_mask_q;
  assign rsp_o.granted_count = out_count_q;
  assign rsp_o.status        = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q       <= work_d;
    run_q        <= run_d;
    grant_q      <= grant_d;
    top_q        <= top_d;
    len_q        <= len_d;
    remain_q     <= remain_d;
    want_q       <= want_d;
    refuse_q     <= refuse_d;
    out_mask_q   <= out_mask_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

endmodule
`default_nettype wire

// File: rtl/contiguous_first_node_allocator_core.sv
// Top level of the contiguous-first node allocator: front, job queue, back.
//
//  channel | dir | payload                                   | request taken when
//  --------+-----+-------------------------------------------+--------------------
//  req_i   | in  | avail_mask[63:0], request_count[6:0]      | valid && ready
//  rsp_o   | out | granted_mask[63:0], granted_count[6:0],   | valid && ready
//          |     | status                                    |
//
// Sequence: the front accepts a request while idle, counts free nodes a byte
// at a time, then hands the request to the queue, waiting while it is full.
// The back pops a request and later registers its result; per round it tries
// window lengths one by one (up to the remaining count), then picks the
// highest window and claims it, while a refused request goes straight from
// the pop to its result.
// The slower side sets the rate: the front for small or refused requests,
// the window scan for large ones.
// Reset clears all control state; there is no clearing pass.
// Stalls: the queue lets the front classify a new request while the back
// works, and the output register lets the back finish while a result waits.
`default_nettype none
module contiguous_first_node_allocator_core #(
  parameter int unsigned NODES  = cfna_pkg::NODES_DEF,
  parameter int unsigned QDEPTH = cfna_pkg::QDEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cfna_req_if.sink   req_i,
  cfna_rsp_if.source rsp_o
);
  import cfna_pkg::*;

  job_t front_job, queue_job;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  // Accept and classify: refuse a zero request or one above the free count.
  cfna_front #(
    .NODES (NODES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  // Hold classified requests so either side can stall on its own.
  cfna_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (queue_job),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  // Claim the highest windows round by round and drive the response.
  cfna_back #(
    .NODES (NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (queue_job),
    .job_valid_i (queue_valid),
    .job_ready_o (queue_ready),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire
